// ----- hw/rtl/utf8sv_pkg.sv -----
// Package: types, codes and constants of the UTF-8 string validator.
`timescale 1ns / 1ps
`default_nettype none

package utf8sv_pkg;

   // Longest string length that still passes in validate mode
   localparam logic [32:0] MAX_STRING_BYTES = 33'h0_FFFF_FFFF;
   // Saturation value of the byte counter and of an unusable end offset
   localparam logic [32:0] COUNT_SAT = 33'h1_FFFF_FFFF;

   // Register byte addresses
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_MODE  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_LIMIT = 3'd4;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_TOO_LONG = 2'd2
   } status_type;

   // Allowed range of the second byte of a multi-byte sequence
   typedef enum logic [2:0] {
      RULE_ANY   = 3'd0,   // 80..BF
      RULE_A0_BF = 3'd1,
      RULE_80_9F = 3'd2,
      RULE_90_BF = 3'd3,
      RULE_80_8F = 3'd4
   } rule_type;

   // Per-string decode state
   typedef struct packed {
      logic [1:0]  bytes_left;
      rule_type    rule;
      logic        expect_second;
      logic [32:0] byte_counter;
      logic [31:0] accepted_length;
      logic [32:0] pending_end;
      logic        halted;
   } dec_state_type;

   localparam dec_state_type DEC_STATE_CLEAR = '{
      bytes_left:      2'd0,
      rule:            RULE_ANY,
      expect_second:   1'b0,
      byte_counter:    33'd0,
      accepted_length: 32'd0,
      pending_end:     33'd0,
      halted:          1'b0
   };

endpackage : utf8sv_pkg

`default_nettype wire

// ----- hw/rtl/utf8sv_csr.sv -----
// Configuration registers: mode and prefix limit behind an APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module utf8sv_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [utf8sv_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                      pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready,
   output logic                                  prefix_mode,
   output logic [31:0]                           prefix_limit
);

   logic        mode_ff, mode_in;
   logic [31:0] limit_ff, limit_in;
   logic        wr_en;
   logic        sel_limit;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   // Registers sit on 4-byte boundaries; bit 2 picks one of the two
   assign sel_limit = (paddr[2] == utf8sv_pkg::CSR_ADDR_LIMIT[2]);

   // Write decode
   always_comb begin
      mode_in  = mode_ff;
      limit_in = limit_ff;
      if (wr_en) begin
         if (sel_limit) begin
            limit_in = pwdata;
         end else begin
            mode_in = pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         limit_ff <= 32'd0;
      end else begin
         mode_ff  <= mode_in;
         limit_ff <= limit_in;
      end
   end

   // Read mux
   always_comb begin
      if (sel_limit) begin
         prdata = limit_ff;
      end else begin
         prdata = {31'd0, mode_ff};
      end
   end

   assign prefix_mode  = mode_ff;
   assign prefix_limit = limit_ff;

endmodule : utf8sv_csr

`default_nettype wire

// ----- hw/rtl/utf8sv_decode.sv -----
// One-byte step of the strict UTF-8 decoder and the end-of-string verdict.
`timescale 1ns / 1ps
`default_nettype none

module utf8sv_decode (
   input  wire utf8sv_pkg::dec_state_type cur_state,
   input  wire logic [7:0]                data_byte,
   input  wire logic                      last_byte,
   input  wire logic                      prefix_mode,
   input  wire logic [31:0]               prefix_limit,
   output utf8sv_pkg::dec_state_type      nxt_state,
   output utf8sv_pkg::status_type         status,
   output logic [31:0]                    prefix_length
);

   utf8sv_pkg::dec_state_type st;
   utf8sv_pkg::rule_type      lead_rule;
   logic [2:0]                lead_len;
   logic                      second_ok;
   logic                      cont_ok;
   logic [33:0]               end_sum;
   logic [32:0]               lead_end;
   logic [32:0]               limit_ext;

   assign limit_ext = {1'b0, prefix_limit};

   // Lead byte classification
   always_comb begin
      lead_len  = 3'd0;
      lead_rule = utf8sv_pkg::RULE_ANY;
      priority if (data_byte >= 8'h01 && data_byte < 8'h80) begin
         lead_len = 3'd1;
      end else if (data_byte >= 8'hc2 && data_byte <= 8'hdf) begin
         lead_len = 3'd2;
      end else if (data_byte == 8'he0) begin
         lead_len  = 3'd3;
         lead_rule = utf8sv_pkg::RULE_A0_BF;
      end else if (data_byte == 8'hed) begin
         lead_len  = 3'd3;
         lead_rule = utf8sv_pkg::RULE_80_9F;
      end else if (data_byte >= 8'he1 && data_byte <= 8'hef) begin
         lead_len = 3'd3;
      end else if (data_byte == 8'hf0) begin
         lead_len  = 3'd4;
         lead_rule = utf8sv_pkg::RULE_90_BF;
      end else if (data_byte >= 8'hf1 && data_byte <= 8'hf3) begin
         lead_len = 3'd4;
      end else if (data_byte == 8'hf4) begin
         lead_len  = 3'd4;
         lead_rule = utf8sv_pkg::RULE_80_8F;
      end else begin
         lead_len = 3'd0;
      end
   end

   // Continuation byte checks
   assign cont_ok = (data_byte[7:6] == 2'b10);
   always_comb begin
      unique case (cur_state.rule)
         utf8sv_pkg::RULE_A0_BF: second_ok = data_byte >= 8'ha0 && data_byte <= 8'hbf;
         utf8sv_pkg::RULE_80_9F: second_ok = data_byte >= 8'h80 && data_byte <= 8'h9f;
         utf8sv_pkg::RULE_90_BF: second_ok = data_byte >= 8'h90 && data_byte <= 8'hbf;
         utf8sv_pkg::RULE_80_8F: second_ok = data_byte >= 8'h80 && data_byte <= 8'h8f;
         default:                second_ok = cont_ok;
      endcase
   end

   // End offset of a sequence starting here; unusable once the prefix broke off
   assign end_sum = {1'b0, cur_state.byte_counter} + {31'd0, lead_len};
   always_comb begin
      if ({1'b0, cur_state.accepted_length} != cur_state.byte_counter) begin
         lead_end = utf8sv_pkg::COUNT_SAT;
      end else if (end_sum[33]) begin
         lead_end = utf8sv_pkg::COUNT_SAT;
      end else begin
         lead_end = end_sum[32:0];
      end
   end

   // State step
   always_comb begin
      st = cur_state;
      if ((!last_byte || prefix_mode) && !cur_state.halted) begin
         if (cur_state.bytes_left == 2'd0) begin
            if (lead_len == 3'd0) begin
               st.halted = 1'b1;
            end else begin
               st.pending_end = lead_end;
               if (lead_len == 3'd1) begin
                  if (lead_end <= limit_ext) begin
                     st.accepted_length = lead_end[31:0];
                  end
               end else begin
                  st.bytes_left    = 2'(lead_len - 3'd1);
                  st.rule          = lead_rule;
                  st.expect_second = 1'b1;
               end
            end
         end else if (!(cur_state.expect_second ? second_ok : cont_ok)) begin
            st.halted = 1'b1;
         end else begin
            st.expect_second = 1'b0;
            st.bytes_left    = cur_state.bytes_left - 2'd1;
            if (cur_state.bytes_left == 2'd1) begin
               st.rule = utf8sv_pkg::RULE_ANY;
               if (cur_state.pending_end <= limit_ext) begin
                  st.accepted_length = cur_state.pending_end[31:0];
               end
            end
         end
      end
      if (cur_state.byte_counter != utf8sv_pkg::COUNT_SAT) begin
         st.byte_counter = cur_state.byte_counter + 33'd1;
      end
   end

   // Verdict on the final byte, then clear for the next string
   always_comb begin
      status        = utf8sv_pkg::STATUS_OK;
      prefix_length = 32'd0;
      if (prefix_mode) begin
         prefix_length = st.accepted_length;
      end else if (st.byte_counter > utf8sv_pkg::MAX_STRING_BYTES) begin
         status = utf8sv_pkg::STATUS_TOO_LONG;
      end else if (data_byte != 8'd0 || st.halted || st.bytes_left != 2'd0) begin
         status = utf8sv_pkg::STATUS_INVALID;
      end
      nxt_state = last_byte ? utf8sv_pkg::DEC_STATE_CLEAR : st;
   end

endmodule : utf8sv_decode

`default_nettype wire

// ----- hw/rtl/utf8_string_validator.sv -----
// Top level: input register, byte decoder, result register and registers port.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/ready     req_data_byte[7:0], req_last_byte
//   rsp      out        rsp_valid/ready     rsp_status[1:0], rsp_prefix_length[31:0]
//   csr      in/out     psel/penable/pready paddr[2:0], pwdata/prdata[31:0]
//
// One byte per cycle while no final byte waits on a stalled result; a request is decoded
// from the input register, and a final byte's result is captured in the result register.
// The per-byte path is the lead-byte end offset add and the prefix limit compare.
// Synchronous reset clears the registers, the decode state and both valid flags.
// A final byte waits in the input register only while an older result is stalled.
`timescale 1ns / 1ps
`default_nettype none

module utf8_string_validator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_data_byte,
   input  wire logic                              req_last_byte,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [1:0]                             rsp_status,
   output logic [31:0]                            rsp_prefix_length,
   // registers port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [utf8sv_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);

   logic        prefix_mode;
   logic [31:0] prefix_limit;

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;
   logic        s1_advance;

   utf8sv_pkg::dec_state_type state_ff, state_in, dec_next;
   utf8sv_pkg::status_type    dec_status;
   logic [31:0]               dec_plen;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_plen_ff;

   utf8sv_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .prefix_mode  (prefix_mode),
      .prefix_limit (prefix_limit)
   );

   // Input register: a final byte moves on only when the result slot frees up
   assign s1_advance  = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   utf8sv_decode u_decode (
      .cur_state     (state_ff),
      .data_byte     (s1_byte_ff),
      .last_byte     (s1_last_ff),
      .prefix_mode   (prefix_mode),
      .prefix_limit  (prefix_limit),
      .nxt_state     (dec_next),
      .status        (dec_status),
      .prefix_length (dec_plen)
   );

   // Decode state
   assign state_in = s1_advance ? dec_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= utf8sv_pkg::DEC_STATE_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result register
   assign rsp_valid_in = (s1_advance && s1_last_ff) ? 1'b1
                       : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_last_ff) begin
         rsp_status_ff <= dec_status;
         rsp_plen_ff   <= dec_plen;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_prefix_length = rsp_plen_ff;

   // A final byte always lands in the result register
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_last_ff |=> rsp_valid_ff)
      else $error("final byte did not produce a result");

   // State is cleared after a final byte
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_last_ff |=> state_ff.byte_counter == 33'd0 && !state_ff.halted)
      else $error("decode state not cleared after final byte");

   // Only validate mode reports errors, and it reports no prefix length
   a_error_no_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != utf8sv_pkg::STATUS_OK |-> rsp_plen_ff == 32'd0)
      else $error("error result carries a prefix length");

   // Second-byte rule is only live inside a sequence
   a_rule_in_sequence: assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_left == 2'd0 |-> state_ff.rule == utf8sv_pkg::RULE_ANY
                                      && !state_ff.expect_second)
      else $error("second-byte rule left over outside a sequence");

   // The accepted prefix never runs ahead of the bytes seen
   a_prefix_bounded: assert property (@(posedge clock) disable iff (reset)
      {1'b0, state_ff.accepted_length} <= state_ff.byte_counter)
      else $error("accepted length exceeds byte count");

endmodule : utf8_string_validator

`default_nettype wire

// ----- tb/utf8_string_checker.sv -----
// Checker: watches the request, result and register ports, predicts and compares results.
`timescale 1ns / 1ps

module utf8_string_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic [7:0]                        req_data_byte,
   input  wire logic                              req_last_byte,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [1:0]                        rsp_status,
   input  wire logic [31:0]                       rsp_prefix_length,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [utf8sv_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                       pwdata,
   input  wire logic [31:0]                       prdata,
   input  wire logic                              pready,
   output int                                     outstanding,
   output int                                     fail_count
);

   typedef struct {
      utf8sv_pkg::status_type status;
      logic [31:0]            prefix_length;
   } verdict_type;

   // Register copies
   logic        cfg_prefix_mode = 1'b0;
   logic [31:0] cfg_prefix_limit = 32'd0;

   // Per-string decode state
   logic [1:0]           seq_left = 2'd0;
   utf8sv_pkg::rule_type seq_rule = utf8sv_pkg::RULE_ANY;
   logic                 seq_second = 1'b0;
   logic [32:0]          byte_count = 33'd0;
   logic [31:0]          good_length = 32'd0;
   logic [32:0]          seq_end = 33'd0;
   logic                 seq_broken = 1'b0;

   verdict_type expected_verdicts[$];
   int          mismatches = 0;
   int          queued = 0;

   assign fail_count  = mismatches;
   assign outstanding = queued;

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic clear_string();
      seq_left    = 2'd0;
      seq_rule    = utf8sv_pkg::RULE_ANY;
      seq_second  = 1'b0;
      byte_count  = 33'd0;
      good_length = 32'd0;
      seq_end     = 33'd0;
      seq_broken  = 1'b0;
   endtask

   function automatic logic second_in_range(input utf8sv_pkg::rule_type rule,
                                            input logic [7:0] b);
      case (rule)
         utf8sv_pkg::RULE_A0_BF: second_in_range = (b >= 8'hA0) && (b <= 8'hBF);
         utf8sv_pkg::RULE_80_9F: second_in_range = (b >= 8'h80) && (b <= 8'h9F);
         utf8sv_pkg::RULE_90_BF: second_in_range = (b >= 8'h90) && (b <= 8'hBF);
         utf8sv_pkg::RULE_80_8F: second_in_range = (b >= 8'h80) && (b <= 8'h8F);
         default:                second_in_range = (b[7:6] == 2'b10);
      endcase
   endfunction

   // A finished sequence extends the prefix only if its end stays within the limit
   task automatic commit_sequence();
      if (seq_end <= {1'b0, cfg_prefix_limit})
         good_length = seq_end[31:0];
   endtask

   // Strict UTF-8 decode of one content byte; start is its offset in the string
   task automatic decode_byte(input logic [7:0] b, input logic [32:0] start);
      logic [2:0]           seq_len;
      utf8sv_pkg::rule_type first_rule;
      logic [33:0]          end_sum;
      logic                 cont_ok;
      seq_len    = 3'd0;
      first_rule = utf8sv_pkg::RULE_ANY;
      if (!seq_broken) begin
         if (seq_left == 2'd0) begin
            if (b >= 8'h01 && b < 8'h80) seq_len = 3'd1;
            else if (b >= 8'hC2 && b <= 8'hDF) seq_len = 3'd2;
            else if (b == 8'hE0) begin
               seq_len = 3'd3;
               first_rule = utf8sv_pkg::RULE_A0_BF;
            end else if (b == 8'hED) begin
               seq_len = 3'd3;
               first_rule = utf8sv_pkg::RULE_80_9F;
            end else if (b >= 8'hE1 && b <= 8'hEF) seq_len = 3'd3;
            else if (b == 8'hF0) begin
               seq_len = 3'd4;
               first_rule = utf8sv_pkg::RULE_90_BF;
            end else if (b >= 8'hF1 && b <= 8'hF3) seq_len = 3'd4;
            else if (b == 8'hF4) begin
               seq_len = 3'd4;
               first_rule = utf8sv_pkg::RULE_80_8F;
            end

            if (seq_len == 3'd0) begin
               seq_broken = 1'b1;
            end else begin
               // once the prefix has stopped, no later end offset is usable
               end_sum = {1'b0, start} + {31'd0, seq_len};
               if ({1'b0, good_length} != start) seq_end = utf8sv_pkg::COUNT_SAT;
               else if (end_sum > {1'b0, utf8sv_pkg::COUNT_SAT})
                  seq_end = utf8sv_pkg::COUNT_SAT;
               else seq_end = end_sum[32:0];
               if (seq_len == 3'd1) begin
                  commit_sequence();
               end else begin
                  seq_left   = seq_len[1:0] - 2'd1;
                  seq_rule   = first_rule;
                  seq_second = 1'b1;
               end
            end
         end else begin
            cont_ok = seq_second ? second_in_range(seq_rule, b) : (b[7:6] == 2'b10);
            if (!cont_ok) begin
               seq_broken = 1'b1;
            end else begin
               seq_second = 1'b0;
               seq_left   = seq_left - 2'd1;
               if (seq_left == 2'd0) begin
                  seq_rule = utf8sv_pkg::RULE_ANY;
                  commit_sequence();
               end
            end
         end
      end
   endtask

   // One accepted byte; the final byte queues the expected verdict
   task automatic track_byte(input logic [7:0] b, input logic last);
      verdict_type v;
      if (!last || cfg_prefix_mode)
         decode_byte(b, byte_count);
      if (byte_count != utf8sv_pkg::COUNT_SAT)
         byte_count = byte_count + 33'd1;
      if (last) begin
         v.status        = utf8sv_pkg::STATUS_OK;
         v.prefix_length = 32'd0;
         if (cfg_prefix_mode)
            v.prefix_length = good_length;
         else if (byte_count > utf8sv_pkg::MAX_STRING_BYTES)
            v.status = utf8sv_pkg::STATUS_TOO_LONG;
         else if (b != 8'h00 || seq_broken || seq_left != 2'd0)
            v.status = utf8sv_pkg::STATUS_INVALID;
         expected_verdicts.push_back(v);
         clear_string();
      end
   endtask

   // Sampled at the edge: every input and output holds its pre-edge value here
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         cfg_prefix_mode  = 1'b0;
         cfg_prefix_limit = 32'd0;
         clear_string();
         expected_verdicts.delete();
      end else begin
         // register port
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == utf8sv_pkg::CSR_ADDR_MODE) cfg_prefix_mode = pwdata[0];
               else if (paddr == utf8sv_pkg::CSR_ADDR_LIMIT) cfg_prefix_limit = pwdata;
            end else if (paddr == utf8sv_pkg::CSR_ADDR_MODE
                         && prdata !== {31'd0, cfg_prefix_mode}) begin
               report_mismatch($sformatf("mode readback %h, want %h", prdata, cfg_prefix_mode));
            end else if (paddr == utf8sv_pkg::CSR_ADDR_LIMIT
                         && prdata !== cfg_prefix_limit) begin
               report_mismatch($sformatf("limit readback %h, want %h",
                                         prdata, cfg_prefix_limit));
            end
         end

         // results before requests: a result never belongs to a byte taken at this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("result with none expected: status %0d length %0d",
                                         rsp_status, rsp_prefix_length));
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_status, want.status));
               if (rsp_prefix_length !== want.prefix_length)
                  report_mismatch($sformatf("prefix length %0d, want %0d",
                                            rsp_prefix_length, want.prefix_length));
            end
         end

         if (req_valid && req_ready)
            track_byte(req_data_byte, req_last_byte);
      end
      queued = expected_verdicts.size();
   end

endmodule

// ----- tb/tb_utf8_string_validator.sv -----
// Testbench top: clock, reset, string and register stimulus, and the final verdict.
`timescale 1ns / 1ps

module tb_utf8_string_validator;

   localparam int RUN_LIMIT    = 400000;
   localparam int DRAIN_CYCLES = 4;
   localparam int BYTE_TARGET  = 525;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [7:0]                        req_data_byte = 8'd0;
   logic                              req_last_byte = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [1:0]                        rsp_status;
   logic [31:0]                       rsp_prefix_length;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [utf8sv_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]                       pwdata = 32'd0;
   logic [31:0]                       prdata;
   logic                              pready;

   int         outstanding;
   int         fail_count;
   int         cycle_count = 0;
   int         bytes_sent = 0;
   int         stall_request = 0;
   bit         idle_on = 1'b1;
   bit         short_strings = 1'b0;
   logic       cur_mode = 1'b0;
   logic [7:0] str_bytes[$];

   utf8_string_validator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_prefix_length(rsp_prefix_length),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   utf8_string_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_prefix_length(rsp_prefix_length),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .outstanding(outstanding), .fail_count(fail_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Run limit
   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("utf8_string_validator regression: fail");
      $finish;
   end

   function automatic int draw_gap();
      draw_gap = idle_on ? $urandom_range(0, 4) : 0;
   endfunction

   // Result side: random back-pressure, plus a long hold when asked
   initial begin
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall_request != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall_request) @(posedge clock);
            stall_request = 0;
         end
         hold = draw_gap();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Valid stays high on return so a back-to-back request keeps it up
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_string();
      for (int i = 0; i < str_bytes.size(); i++)
         send_byte(str_bytes[i], i == str_bytes.size() - 1);
   endtask

   // Drop valid, wait for every result, then let the pipeline empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB transfer; psel is left up so a following transfer can start at once
   task automatic csr_access(input logic wr, input logic [utf8sv_pkg::CSR_ADDR_W-1:0] addr,
                             input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
   endtask

   task automatic configure(input logic mode, input logic [31:0] limit);
      wait_idle();
      csr_access(1'b1, utf8sv_pkg::CSR_ADDR_MODE, {31'd0, mode});
      csr_access(1'b0, utf8sv_pkg::CSR_ADDR_MODE, 32'd0);
      csr_access(1'b1, utf8sv_pkg::CSR_ADDR_LIMIT, limit);
      csr_access(1'b0, utf8sv_pkg::CSR_ADDR_LIMIT, 32'd0);
      psel    <= 1'b0;
      penable <= 1'b0;
      cur_mode = mode;
   endtask

   function automatic int unsigned pick_code_point();
      int unsigned cp;
      case ($urandom_range(0, 9))
         0: begin
            // boundaries of each encoding length and around the surrogates
            case ($urandom_range(0, 9))
               0: cp = 'h1;
               1: cp = 'h7F;
               2: cp = 'h80;
               3: cp = 'h7FF;
               4: cp = 'h800;
               5: cp = 'hFFFF;
               6: cp = 'hD7FF;
               7: cp = 'hE000;
               8: cp = 'h10000;
               default: cp = 'h10FFFF;
            endcase
         end
         1, 2, 3: cp = $urandom_range(1, 'h7F);
         4, 5:    cp = $urandom_range('h80, 'h7FF);
         6, 7: begin
            cp = $urandom_range('h800, 'hFFFF);
            if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp - 'h800;
         end
         default: cp = $urandom_range('h10000, 'h10FFFF);
      endcase
      pick_code_point = cp;
   endfunction

   task automatic append_code_point(input int unsigned cp);
      if (cp < 'h80) begin
         str_bytes.push_back(cp[7:0]);
      end else if (cp < 'h800) begin
         str_bytes.push_back({3'b110, cp[10:6]});
         str_bytes.push_back({2'b10, cp[5:0]});
      end else if (cp < 'h10000) begin
         str_bytes.push_back({4'b1110, cp[15:12]});
         str_bytes.push_back({2'b10, cp[11:6]});
         str_bytes.push_back({2'b10, cp[5:0]});
      end else begin
         str_bytes.push_back({5'b11110, cp[20:18]});
         str_bytes.push_back({2'b10, cp[17:12]});
         str_bytes.push_back({2'b10, cp[11:6]});
         str_bytes.push_back({2'b10, cp[5:0]});
      end
   endtask

   // Mostly well-formed strings; some get a stray, lost or replaced byte, or junk
   task automatic make_string();
      int  n_chars;
      int  pos;
      logic nul_kind;
      str_bytes.delete();
      nul_kind = !cur_mode;
      if ($urandom_range(0, 7) == 0) nul_kind = !nul_kind;
      n_chars = $urandom_range(0, short_strings ? 1 : 6);
      repeat (n_chars) append_code_point(pick_code_point());
      case ($urandom_range(0, 11))
         0: begin
            pos = $urandom_range(0, str_bytes.size());
            str_bytes.insert(pos, 8'($urandom_range(0, 255)));
         end
         1: if (str_bytes.size() > 0) str_bytes.delete(str_bytes.size() - 1);
         2: if (str_bytes.size() > 0) begin
            pos = $urandom_range(0, str_bytes.size() - 1);
            str_bytes[pos] = 8'($urandom_range(0, 255));
         end
         3: begin
            str_bytes.delete();
            repeat ($urandom_range(1, 5)) str_bytes.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
      if (nul_kind) begin
         if ($urandom_range(0, 9) == 0) str_bytes.push_back(8'($urandom_range(1, 255)));
         else str_bytes.push_back(8'h00);
      end else if (str_bytes.size() == 0) begin
         str_bytes.push_back(8'($urandom_range(1, 127)));
      end
   endtask

   initial begin
      int   n_strings;
      int   phase;
      logic [31:0] limit;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Validate mode: empty string, bad terminator, embedded NUL and decode errors
      configure(1'b0, 32'hFFFF_FFFF);
      str_bytes = '{8'h00};                      send_string();
      str_bytes = '{8'h7F, 8'hFF};               send_string();
      str_bytes = '{8'h00, 8'h00};               send_string();
      str_bytes = '{8'hC0, 8'h00};               send_string();  // overlong lead
      str_bytes = '{8'hED, 8'hA0, 8'h00};        send_string();  // surrogate
      str_bytes = '{8'hF4, 8'h90, 8'h00};        send_string();  // above U+10FFFF
      str_bytes = '{8'hE2, 8'h82, 8'h00};        send_string();  // unfinished

      // Prefix mode: stop at the limit, stop at a bad continuation
      configure(1'b1, 32'd5);
      str_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'h41, 8'h42}; send_string();
      str_bytes = '{8'h41, 8'hC3, 8'h28};        send_string();

      // Random phases of register settings and strings
      phase = 0;
      while (bytes_sent < BYTE_TARGET) begin
         case ($urandom_range(0, 5))
            0:       limit = 32'd0;
            1:       limit = 32'hFFFF_FFFF;
            2, 3:    limit = $urandom_range(0, 24);
            4:       limit = $urandom_range(0, 8);
            default: limit = $urandom;
         endcase
         configure(1'($urandom_range(0, 1)), limit);
         idle_on       = ($urandom_range(0, 3) != 0);
         short_strings = 1'b0;
         n_strings     = $urandom_range(5, 12);
         if (phase == 2 || phase == 7) begin
            // receiver holds off while short strings keep coming
            idle_on       = 1'b0;
            short_strings = 1'b1;
            n_strings     = 20;
            stall_request = 80;
         end
         repeat (n_strings) begin
            make_string();
            send_string();
         end
         phase++;
      end

      wait_idle();
      if (fail_count == 0)
         $display("utf8_string_validator regression: pass");
      else
         $display("utf8_string_validator regression: fail");
      $finish;
   end

endmodule
